### rtl/cta_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cta_pkg
// Shared widths, codes and record types of the command tag allocator.
// ----------------------------------------------------------------------------
package cta_pkg;

  // geometry of the id space and the busy bitmap
  localparam int MaxDepth = 1024;
  localparam int IdW      = $clog2(MaxDepth);
  localparam int DepthW   = IdW + 1;
  localparam int WordW    = 64;
  localparam int BitW     = $clog2(WordW);
  localparam int SpanW    = BitW + 1;
  localparam int NumWords = MaxDepth / WordW;
  localparam int WAddrW   = $clog2(NumWords);

  // payload widths
  localparam int KindW    = 2;
  localparam int CmdIdW   = 16;
  localparam int CtxBits  = 32;
  localparam int HdlW     = 8;
  localparam int StatusW  = 2;
  localparam int MarkW    = 2;

  // register reset value
  localparam logic [DepthW-1:0] DepthReset = DepthW'(MaxDepth);

  // request kinds
  localparam logic [KindW-1:0] KIND_ALLOC  = 2'd0;
  localparam logic [KindW-1:0] KIND_FREE   = 2'd1;
  localparam logic [KindW-1:0] KIND_CANCEL = 2'd2;

  // result status
  localparam logic [StatusW-1:0] ST_DONE  = 2'd0;
  localparam logic [StatusW-1:0] ST_BUSY  = 2'd1;
  localparam logic [StatusW-1:0] ST_RANGE = 2'd2;

  // entry marks
  localparam logic [MarkW-1:0] MARK_LIVE      = 2'd0;
  localparam logic [MarkW-1:0] MARK_CANCELLED = 2'd1;
  localparam logic [MarkW-1:0] MARK_COMPLETED = 2'd2;
  localparam logic [MarkW-1:0] MARK_INVALID   = 2'd3;

  // one entry of the tag memory
  typedef struct packed {
    logic [CtxBits-1:0] ctx;
    logic [HdlW-1:0]    hdl;
    logic [MarkW-1:0]   mark;
  } cta_entry_t;

  // one result word
  typedef struct packed {
    logic [StatusW-1:0] status;
    logic [IdW-1:0]     granted_id;
    logic [CtxBits-1:0] stored_context;
    logic [HdlW-1:0]    stored_handler;
    logic [MarkW-1:0]   context_mark;
  } cta_res_t;

  // access to the busy bitmap memory
  typedef struct packed {
    logic              re;
    logic [WAddrW-1:0] raddr;
    logic              we;
    logic [WAddrW-1:0] waddr;
    logic [WordW-1:0]  wdata;
  } cta_busy_req_t;

  // access to the tag memory
  typedef struct packed {
    logic       re;
    logic [IdW-1:0] raddr;
    logic       we;
    logic [IdW-1:0] waddr;
    cta_entry_t wdata;
  } cta_entry_req_t;

  // outcome of scanning one bitmap word
  typedef struct packed {
    logic             found;
    logic [BitW-1:0]  bit_idx;
    logic [IdW-1:0]   id;
    logic [SpanW-1:0] n;
    logic [IdW-1:0]   cur_next;
  } cta_scan_t;

endpackage

### rtl/cta_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cta_if
// Valid/ready channels of the command tag allocator: command, response and
// depth register write.
// ----------------------------------------------------------------------------
interface cta_cmd_if;
  import cta_pkg::*;

  logic                valid;
  logic                ready;
  logic [KindW-1:0]    kind;
  logic [CmdIdW-1:0]   cmd_id;
  logic [CtxBits-1:0]  context_tag;
  logic [HdlW-1:0]     handler_tag;

  modport source (output valid, kind, cmd_id, context_tag, handler_tag, input ready);
  modport sink   (input valid, kind, cmd_id, context_tag, handler_tag, output ready);
endinterface

interface cta_rsp_if;
  import cta_pkg::*;

  logic                valid;
  logic                ready;
  logic [StatusW-1:0]  status;
  logic [IdW-1:0]      granted_id;
  logic [CtxBits-1:0]  stored_context;
  logic [HdlW-1:0]     stored_handler;
  logic [MarkW-1:0]    context_mark;

  modport source (output valid, status, granted_id, stored_context, stored_handler,
                  context_mark, input ready);
  modport sink   (input valid, status, granted_id, stored_context, stored_handler,
                  context_mark, output ready);
endinterface

interface cta_cfg_if;
  import cta_pkg::*;

  logic              valid;
  logic              ready;
  logic [DepthW-1:0] depth_in_use;

  modport source (output valid, depth_in_use, input ready);
  modport sink   (input valid, depth_in_use, output ready);
endinterface

### rtl/cta_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cta_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module cta_ram #(
  parameter int Width = 8,
  parameter int Depth = 16,
  localparam int AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // read port, data holds until the next read
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/cta_scan.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cta_scan
// Evaluates one 64-bit busy word: which ids are candidates from the current
// pointer, the first clear one among them, and where the pointer goes next.
// ----------------------------------------------------------------------------
module cta_scan (
  input  logic [cta_pkg::WordW-1:0]  word_i,
  input  logic [cta_pkg::IdW-1:0]    cur_i,
  input  logic [cta_pkg::IdW-1:0]    limit_i,
  input  logic [cta_pkg::DepthW-1:0] rem_i,
  output cta_pkg::cta_scan_t         scan_o
);
  import cta_pkg::*;

  logic [BitW-1:0]   start;
  logic [SpanW-1:0]  span_word;
  logic [IdW-1:0]    span_lim;
  logic [IdW-1:0]    n0;
  logic [DepthW-1:0] n1;
  logic [SpanW-1:0]  n;
  logic [WordW-1:0]  mask;
  logic [WordW-1:0]  free_bits;
  logic [BitW-1:0]   idx;
  logic [DepthW-1:0] sum;

  // number of candidates in this word
  always_comb begin
    start     = cur_i[BitW-1:0];
    span_word = SpanW'(WordW) - {1'b0, start};
    span_lim  = (cur_i < limit_i) ? (limit_i - cur_i) : IdW'(1);
    n0        = (span_lim < IdW'(span_word)) ? span_lim : IdW'(span_word);
    n1        = (rem_i < {1'b0, n0}) ? rem_i : {1'b0, n0};
    n         = n1[SpanW-1:0];
  end

  // candidate mask and first clear bit
  always_comb begin
    mask      = (~({WordW{1'b1}} << n)) << start;
    free_bits = ~word_i & mask;
    idx       = '0;
    for (int i = WordW - 1; i >= 0; i--) begin
      if (free_bits[i]) begin
        idx = BitW'(i);
      end
    end
  end

  // pointer after the last candidate, wrapping at the limit
  always_comb begin
    sum = {1'b0, cur_i} + DepthW'(n);
    scan_o.found    = |free_bits;
    scan_o.bit_idx  = idx;
    scan_o.id       = {cur_i[IdW-1:BitW], idx};
    scan_o.n        = n;
    scan_o.cur_next = (sum >= {1'b0, limit_i}) ? '0 : sum[IdW-1:0];
  end

endmodule

### rtl/cta_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cta_ctrl
// Sequencer of the allocator: clearing pass, word-by-word bitmap scan for
// allocate, and read-modify-write of the bitmap and tag memory for free and
// cancel.
// ----------------------------------------------------------------------------
module cta_ctrl (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic [cta_pkg::DepthW-1:0]  depth_i,
  cta_cmd_if.sink                     cmd_i,
  output cta_pkg::cta_busy_req_t      busy_req_o,
  input  logic [cta_pkg::WordW-1:0]   busy_rdata_i,
  output cta_pkg::cta_entry_req_t     entry_req_o,
  input  cta_pkg::cta_entry_t         entry_rdata_i,
  output logic                        res_valid_o,
  input  logic                        res_ready_i,
  output cta_pkg::cta_res_t           res_o
);
  import cta_pkg::*;

  localparam logic [2:0] S_CLEAR  = 3'd0;
  localparam logic [2:0] S_IDLE   = 3'd1;
  localparam logic [2:0] S_EVAL_A = 3'd2;
  localparam logic [2:0] S_EVAL_U = 3'd3;
  localparam logic [2:0] S_PUT    = 3'd4;

  logic [2:0]         state_q, state_d;
  logic [IdW-1:0]     clr_q, clr_d;
  logic [IdW-1:0]     ptr_q, ptr_d;
  logic [IdW-1:0]     cur_q, cur_d;
  logic [DepthW-1:0]  rem_q, rem_d;
  logic [KindW-1:0]   kind_q, kind_d;
  logic [IdW-1:0]     id_q, id_d;
  logic [CtxBits-1:0] ctx_q, ctx_d;
  logic [HdlW-1:0]    hdl_q, hdl_d;
  cta_res_t           res_q, res_d;

  logic [DepthW-1:0]  limit_w;
  logic [IdW-1:0]     limit;
  cta_scan_t          scan;
  logic [DepthW-1:0]  rem_left;
  logic [DepthW-1:0]  id_inc;
  logic [IdW-1:0]     ptr_after;
  cta_entry_t         ent;

  // last pointer value before wrap is depth minus two
  assign limit_w = depth_i - DepthW'(1);
  assign limit   = limit_w[IdW-1:0];

  cta_scan u_scan (
    .word_i  (busy_rdata_i),
    .cur_i   (cur_q),
    .limit_i (limit),
    .rem_i   (rem_q),
    .scan_o  (scan)
  );

  assign rem_left  = rem_q - DepthW'(scan.n);
  assign id_inc    = {1'b0, scan.id} + DepthW'(1);
  assign ptr_after = (id_inc >= {1'b0, limit}) ? '0 : id_inc[IdW-1:0];
  assign ent       = entry_rdata_i;

  assign cmd_i.ready = (state_q == S_IDLE);
  assign res_valid_o = (state_q == S_PUT);
  assign res_o       = res_q;

  // next state and memory accesses
  always_comb begin
    state_d     = state_q;
    clr_d       = clr_q;
    ptr_d       = ptr_q;
    cur_d       = cur_q;
    rem_d       = rem_q;
    kind_d      = kind_q;
    id_d        = id_q;
    ctx_d       = ctx_q;
    hdl_d       = hdl_q;
    res_d       = res_q;
    busy_req_o  = '0;
    entry_req_o = '0;

    case (state_q)
      S_CLEAR: begin
        busy_req_o.we          = 1'b1;
        busy_req_o.waddr       = clr_q[IdW-1:BitW];
        entry_req_o.we         = 1'b1;
        entry_req_o.waddr      = clr_q;
        entry_req_o.wdata.mark = MARK_COMPLETED;
        clr_d                  = clr_q + IdW'(1);
        if (clr_q == IdW'(MaxDepth - 1)) begin
          state_d = S_IDLE;
        end
      end

      S_IDLE: begin
        if (cmd_i.valid) begin
          kind_d = cmd_i.kind;
          id_d   = cmd_i.cmd_id[IdW-1:0];
          ctx_d  = cmd_i.context_tag;
          hdl_d  = cmd_i.handler_tag;
          res_d  = '0;
          if (cmd_i.kind == KIND_ALLOC) begin
            cur_d            = ptr_q;
            rem_d            = depth_i;
            busy_req_o.re    = 1'b1;
            busy_req_o.raddr = ptr_q[IdW-1:BitW];
            state_d          = S_EVAL_A;
          end else if (cmd_i.kind == KIND_FREE || cmd_i.kind == KIND_CANCEL) begin
            if (cmd_i.cmd_id >= CmdIdW'(depth_i)) begin
              res_d.status       = ST_RANGE;
              res_d.context_mark = MARK_INVALID;
              state_d            = S_PUT;
            end else begin
              busy_req_o.re     = 1'b1;
              busy_req_o.raddr  = cmd_i.cmd_id[IdW-1:BitW];
              entry_req_o.re    = 1'b1;
              entry_req_o.raddr = cmd_i.cmd_id[IdW-1:0];
              state_d           = S_EVAL_U;
            end
          end else begin
            state_d = S_PUT;
          end
        end
      end

      // one bitmap word per cycle, next word read issued alongside
      S_EVAL_A: begin
        if (scan.found) begin
          busy_req_o.we          = 1'b1;
          busy_req_o.waddr       = cur_q[IdW-1:BitW];
          busy_req_o.wdata       = busy_rdata_i | ({{(WordW-1){1'b0}}, 1'b1} << scan.bit_idx);
          entry_req_o.we         = 1'b1;
          entry_req_o.waddr      = scan.id;
          entry_req_o.wdata.ctx  = ctx_q;
          entry_req_o.wdata.hdl  = hdl_q;
          entry_req_o.wdata.mark = MARK_LIVE;
          ptr_d                  = ptr_after;
          res_d.status           = ST_DONE;
          res_d.granted_id       = scan.id;
          state_d                = S_PUT;
        end else if (rem_left == '0) begin
          ptr_d        = scan.cur_next;
          res_d.status = ST_BUSY;
          state_d      = S_PUT;
        end else begin
          cur_d            = scan.cur_next;
          rem_d            = rem_left;
          busy_req_o.re    = 1'b1;
          busy_req_o.raddr = scan.cur_next[IdW-1:BitW];
        end
      end

      // free or cancel: return the tags of a live entry, rewrite the mark, and clear the busy bit on free
      S_EVAL_U: begin
        res_d.context_mark = ent.mark;
        if (ent.mark == MARK_LIVE) begin
          res_d.stored_context = ent.ctx;
          res_d.stored_handler = ent.hdl;
        end
        entry_req_o.we        = 1'b1;
        entry_req_o.waddr     = id_q;
        entry_req_o.wdata.ctx = ent.ctx;
        entry_req_o.wdata.hdl = ent.hdl;
        if (kind_q == KIND_FREE) begin
          entry_req_o.wdata.mark = MARK_COMPLETED;
          busy_req_o.we          = 1'b1;
          busy_req_o.waddr       = id_q[IdW-1:BitW];
          busy_req_o.wdata       = busy_rdata_i
                                   & ~({{(WordW-1){1'b0}}, 1'b1} << id_q[BitW-1:0]);
        end else begin
          entry_req_o.wdata.mark = MARK_CANCELLED;
        end
        state_d = S_PUT;
      end

      S_PUT: begin
        if (res_ready_i) begin
          state_d = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      clr_q   <= '0;
      ptr_q   <= '0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      ptr_q   <= ptr_d;
    end
  end

  // working registers of the current word
  always_ff @(posedge clk_i) begin
    cur_q  <= cur_d;
    rem_q  <= rem_d;
    kind_q <= kind_d;
    id_q   <= id_d;
    ctx_q  <= ctx_d;
    hdl_q  <= hdl_d;
    res_q  <= res_d;
  end

endmodule

### rtl/command_tag_allocator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// command_tag_allocator
// Round-robin command id allocator with per-id context and handler tags.
// ----------------------------------------------------------------------------
// Channels: cmd_i takes one word per request (allocate, free or cancel with
// id and tags), rsp_o returns exactly one word per request, cfg_i writes the
// queue depth (saturated to 2..1024) and is always ready; write it only while
// no request is in flight.
// The busy bitmap lives in a 16 x 64-bit memory, the tags and marks in a
// 1024-entry memory. Allocate scans the bitmap one 64-bit word per cycle from
// the rotating pointer, visiting at most 17 words (depth tries).
// Free and cancel read, then modify and write, then pass the result to rsp_o.
// One request is in flight at a time; the next is taken as soon as the
// previous result sits in the output register, even if rsp_o is stalled.
// A stalled rsp_o holds its word and stops further results, not acceptance
// of the next request.
// After reset a clearing pass over all 1024 ids empties the bitmap and marks
// every entry completed; cmd_i is not ready during it, cfg_i is.
// ----------------------------------------------------------------------------
module command_tag_allocator (
  input  logic       clk_i,
  input  logic       rst_ni,
  cta_cmd_if.sink    cmd_i,
  cta_rsp_if.source  rsp_o,
  cta_cfg_if.sink    cfg_i
);
  import cta_pkg::*;

  logic [DepthW-1:0] depth_q;
  logic [DepthW-1:0] depth_eff;
  cta_busy_req_t     busy_req;
  cta_entry_req_t    entry_req;
  logic [WordW-1:0]  busy_rdata;
  cta_entry_t        entry_rdata;
  logic              res_valid;
  logic              res_ready;
  cta_res_t          res;
  logic              out_valid_q;
  cta_res_t          out_q;

  // depth register
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      depth_q <= DepthReset;
    end else if (cfg_i.valid) begin
      depth_q <= cfg_i.depth_in_use;
    end
  end

  // saturate to the supported range
  always_comb begin
    if (depth_q < DepthW'(2)) begin
      depth_eff = DepthW'(2);
    end else if (depth_q > DepthW'(MaxDepth)) begin
      depth_eff = DepthW'(MaxDepth);
    end else begin
      depth_eff = depth_q;
    end
  end

  // busy bitmap
  cta_ram #(.Width(WordW), .Depth(NumWords)) u_busy_ram (
    .clk_i   (clk_i),
    .we_i    (busy_req.we),
    .waddr_i (busy_req.waddr),
    .wdata_i (busy_req.wdata),
    .re_i    (busy_req.re),
    .raddr_i (busy_req.raddr),
    .rdata_o (busy_rdata)
  );

  // tags and marks
  cta_ram #(.Width($bits(cta_entry_t)), .Depth(MaxDepth)) u_entry_ram (
    .clk_i   (clk_i),
    .we_i    (entry_req.we),
    .waddr_i (entry_req.waddr),
    .wdata_i (entry_req.wdata),
    .re_i    (entry_req.re),
    .raddr_i (entry_req.raddr),
    .rdata_o (entry_rdata)
  );

  cta_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .depth_i       (depth_eff),
    .cmd_i         (cmd_i),
    .busy_req_o    (busy_req),
    .busy_rdata_i  (busy_rdata),
    .entry_req_o   (entry_req),
    .entry_rdata_i (entry_rdata),
    .res_valid_o   (res_valid),
    .res_ready_i   (res_ready),
    .res_o         (res)
  );

  // output register
  assign res_ready = !out_valid_q || rsp_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready && res_valid) begin
      out_q <= res;
    end
  end

  assign rsp_o.valid          = out_valid_q;
  assign rsp_o.status         = out_q.status;
  assign rsp_o.granted_id     = out_q.granted_id;
  assign rsp_o.stored_context = out_q.stored_context;
  assign rsp_o.stored_handler = out_q.stored_handler;
  assign rsp_o.context_mark   = out_q.context_mark;

endmodule
